// ===== src/uart_line_buffered_fifos_core_macros.svh =====
// assertion macros for the serial port line FIFOs
`ifndef UART_LINE_BUFFERED_FIFOS_CORE_MACROS_SVH
`define UART_LINE_BUFFERED_FIFOS_CORE_MACROS_SVH
`ifndef SYNTH
`define ULBF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ulbf assertion failed");
`define ULBF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ulbf assertion failed");
`else
`define ULBF_ASSERT(lbl, clk, rstn, prop)
`define ULBF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/ulbf_pkg.sv =====
package ulbf_pkg;

    localparam int RX_DEPTH_DEF = 32;
    localparam int TX_DEPTH_DEF = 32;

    localparam int ADDR_W  = 3;
    localparam int REG_EOL = 0;

    localparam logic [7:0] EOL_RESET = 8'd13;
    localparam logic [7:0] NL_BYTE   = 8'd10;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] LINES_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_HOST_RD = 2'd1,
        CMD_HOST_WR = 2'd2,
        CMD_TX_RDY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OVF_B   = 2'd0,
        OVF_O   = 2'd1,
        OVF_F   = 2'd2,
        OVF_EOL = 2'd3
    } t_ovf_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RXRD,
        S_TXRD,
        S_OVF
    } t_state;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_empty;
        logic       write_rejected;
        logic       overflow;
        logic       last;
    } t_result;

endpackage

// ===== src/uart_line_buffered_fifos_core.sv =====
// Receive and transmit byte FIFOs of a serial port with line discipline.
// Input stream: tuser carries the command (line byte received, host read,
// host write, transmitter ready), tdata the byte. Each beat gives one
// result beat; a line byte that finds the receive FIFO full clears it and
// gives four beats (B, O, F, end-of-line on the wire, tlast on the fourth).
// Timing: line byte, host write, empty host read and empty transmitter
// ready give their result in the cycle after acceptance; a host read or
// transmitter ready that pops a byte passes the FIFO RAM's registered read
// port and then the output register. Throughput: one beat per cycle for
// non-popping commands while results are taken; a pop or overflow keeps
// tready low until its last result loads. One item is in flight at a time.
// The result sits in an output register; the next beat is accepted while
// that register is taken in the same cycle. When the receiver stalls, the
// result holds and input tready drops until it is taken.
// Reset clears pointers, counts and the line count and sets end-of-line
// to 13; RAM contents are not cleared. APB register 0 holds the end-of-line
// byte; the user must write it only while the block is idle (not enforced).
`include "uart_line_buffered_fifos_core_macros.svh"

module uart_line_buffered_fifos_core #(
    parameter int RX_DEPTH = ulbf_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ulbf_pkg::TX_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ulbf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input beats
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                  s_axis_tuser,  // [1:0] command
    // result beats
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // [7:0] line_byte, [15:8] read_byte
    output logic [4:0]                  m_axis_tuser,  // [0] line_valid, [1] read_valid,
                                                       // [2] read_empty, [3] write_rejected,
                                                       // [4] overflow
    output logic                        m_axis_tlast
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    ulbf_pkg::t_state   r_state, n_state;
    ulbf_pkg::t_result  r_res, n_res;
    ulbf_pkg::t_ovf_idx r_ovf_idx, n_ovf_idx;
    logic               r_ovalid;
    logic               w_load;
    logic [7:0]         r_eol;

    logic [RX_AW-1:0] r_rx_wpos, n_rx_wpos, r_rx_rpos, n_rx_rpos;
    logic [RX_CW-1:0] r_rx_count, n_rx_count;
    logic [7:0]       r_rx_lines, n_rx_lines;
    logic [TX_AW-1:0] r_tx_wpos, n_tx_wpos, r_tx_rpos, n_tx_rpos;
    logic [TX_CW-1:0] r_tx_count, n_tx_count;

    logic       w_rx_we, w_rx_re, w_tx_we, w_tx_re;
    logic [7:0] w_rx_rdata, w_tx_rdata, w_wr_byte;
    logic       w_in_fire, w_out_free, w_rx_full, w_tx_full, w_cfg_wr, w_cfg_hit;
    ulbf_pkg::t_cmd w_cmd;

    assign w_cmd      = ulbf_pkg::t_cmd'(s_axis_tuser);
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ulbf_pkg::S_IDLE) && w_out_free;
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_rx_full  = (r_rx_count == RX_CW'(RX_DEPTH));
    assign w_tx_full  = (r_tx_count == TX_CW'(TX_DEPTH));
    assign w_wr_byte  = (s_axis_tdata == ulbf_pkg::NL_BYTE) ? r_eol : s_axis_tdata;

    // configuration
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr == ulbf_pkg::ADDR_W'(ulbf_pkg::REG_EOL * 4));
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_hit;
    assign prdata    = w_cfg_hit ? {24'd0, r_eol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eol <= ulbf_pkg::EOL_RESET;
        end else if (w_cfg_wr) begin
            r_eol <= pwdata[7:0];
        end
    end

    ulbf_ram #(.W(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_we),
        .i_waddr (r_rx_wpos),
        .i_wdata (s_axis_tdata),
        .i_re    (w_rx_re),
        .i_raddr (r_rx_rpos),
        .o_rdata (w_rx_rdata)
    );

    ulbf_ram #(.W(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (r_tx_wpos),
        .i_wdata (w_wr_byte),
        .i_re    (w_tx_re),
        .i_raddr (r_tx_rpos),
        .o_rdata (w_tx_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ulbf_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    case (w_cmd)
                        ulbf_pkg::CMD_RX_BYTE: begin
                            if (w_rx_full) n_state = ulbf_pkg::S_OVF;
                        end
                        ulbf_pkg::CMD_HOST_RD: begin
                            if (r_rx_count != '0 && r_rx_lines != '0) begin
                                n_state = ulbf_pkg::S_RXRD;
                            end
                        end
                        ulbf_pkg::CMD_TX_RDY: begin
                            if (r_tx_count != '0) n_state = ulbf_pkg::S_TXRD;
                        end
                        default: n_state = ulbf_pkg::S_IDLE;
                    endcase
                end
            end
            ulbf_pkg::S_RXRD: n_state = ulbf_pkg::S_IDLE;
            ulbf_pkg::S_TXRD: n_state = ulbf_pkg::S_IDLE;
            ulbf_pkg::S_OVF: begin
                if (w_out_free && r_ovf_idx == ulbf_pkg::OVF_EOL) n_state = ulbf_pkg::S_IDLE;
            end
            default: n_state = ulbf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_rx_wpos  = r_rx_wpos;
        n_rx_rpos  = r_rx_rpos;
        n_rx_count = r_rx_count;
        n_rx_lines = r_rx_lines;
        n_tx_wpos  = r_tx_wpos;
        n_tx_rpos  = r_tx_rpos;
        n_tx_count = r_tx_count;
        n_ovf_idx  = r_ovf_idx;
        w_rx_we    = 1'b0;
        w_rx_re    = 1'b0;
        w_tx_we    = 1'b0;
        w_tx_re    = 1'b0;
        w_load     = 1'b0;
        n_res      = '0;
        n_res.last = 1'b1;
        case (r_state)
            ulbf_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    case (w_cmd)
                        ulbf_pkg::CMD_RX_BYTE: begin
                            if (!w_rx_full) begin
                                w_rx_we = 1'b1;
                                if (s_axis_tdata == r_eol && r_rx_lines != ulbf_pkg::LINES_MAX) begin
                                    n_rx_lines = r_rx_lines + 8'd1;
                                end
                                n_rx_wpos  = (r_rx_wpos == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                                 : r_rx_wpos + 1'b1;
                                n_rx_count = r_rx_count + 1'b1;
                                w_load     = 1'b1;
                            end else begin
                                n_rx_wpos  = '0;
                                n_rx_rpos  = '0;
                                n_rx_count = '0;
                                n_rx_lines = '0;
                                n_ovf_idx  = ulbf_pkg::OVF_B;
                            end
                        end
                        ulbf_pkg::CMD_HOST_RD: begin
                            if (r_rx_count == '0 || r_rx_lines == '0) begin
                                w_load           = 1'b1;
                                n_res.read_empty = 1'b1;
                            end else begin
                                w_rx_re    = 1'b1;
                                n_rx_rpos  = (r_rx_rpos == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                                 : r_rx_rpos + 1'b1;
                                n_rx_count = r_rx_count - 1'b1;
                            end
                        end
                        ulbf_pkg::CMD_HOST_WR: begin
                            w_load = 1'b1;
                            if (w_tx_full) begin
                                n_res.write_rejected = 1'b1;
                            end else begin
                                w_tx_we    = 1'b1;
                                n_tx_wpos  = (r_tx_wpos == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                                 : r_tx_wpos + 1'b1;
                                n_tx_count = r_tx_count + 1'b1;
                            end
                        end
                        ulbf_pkg::CMD_TX_RDY: begin
                            if (r_tx_count != '0) begin
                                w_tx_re    = 1'b1;
                                n_tx_rpos  = (r_tx_rpos == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                                 : r_tx_rpos + 1'b1;
                                n_tx_count = r_tx_count - 1'b1;
                            end else begin
                                w_load = 1'b1;
                            end
                        end
                        default: w_load = 1'b0;
                    endcase
                end
            end
            ulbf_pkg::S_RXRD: begin
                w_load           = 1'b1;
                n_res.read_valid = 1'b1;
                if (w_rx_rdata == r_eol) begin
                    n_res.read_byte = ulbf_pkg::NL_BYTE;
                    n_rx_lines      = r_rx_lines - 8'd1;
                end else begin
                    n_res.read_byte = w_rx_rdata;
                end
            end
            ulbf_pkg::S_TXRD: begin
                w_load           = 1'b1;
                n_res.line_valid = 1'b1;
                n_res.line_byte  = w_tx_rdata;
            end
            ulbf_pkg::S_OVF: begin
                n_res.line_valid = 1'b1;
                n_res.overflow   = 1'b1;
                n_res.last       = (r_ovf_idx == ulbf_pkg::OVF_EOL);
                case (r_ovf_idx)
                    ulbf_pkg::OVF_B: n_res.line_byte = ulbf_pkg::CH_B;
                    ulbf_pkg::OVF_O: n_res.line_byte = ulbf_pkg::CH_O;
                    ulbf_pkg::OVF_F: n_res.line_byte = ulbf_pkg::CH_F;
                    default:         n_res.line_byte = r_eol;
                endcase
                if (w_out_free) begin
                    w_load    = 1'b1;
                    n_ovf_idx = ulbf_pkg::t_ovf_idx'(r_ovf_idx + 2'd1);
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ulbf_pkg::S_IDLE;
            r_ovf_idx  <= ulbf_pkg::OVF_B;
            r_ovalid   <= 1'b0;
            r_rx_wpos  <= '0;
            r_rx_rpos  <= '0;
            r_rx_count <= '0;
            r_rx_lines <= '0;
            r_tx_wpos  <= '0;
            r_tx_rpos  <= '0;
            r_tx_count <= '0;
        end else begin
            r_state    <= n_state;
            r_ovf_idx  <= n_ovf_idx;
            r_rx_wpos  <= n_rx_wpos;
            r_rx_rpos  <= n_rx_rpos;
            r_rx_count <= n_rx_count;
            r_rx_lines <= n_rx_lines;
            r_tx_wpos  <= n_tx_wpos;
            r_tx_rpos  <= n_tx_rpos;
            r_tx_count <= n_tx_count;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_res.read_byte, r_res.line_byte};
    assign m_axis_tuser  = {r_res.overflow, r_res.write_rejected, r_res.read_empty,
                            r_res.read_valid, r_res.line_valid};
    assign m_axis_tlast  = r_res.last;

    `ULBF_ASSERT(a_rx_count_bound, i_clk, i_rst_n, r_rx_count <= RX_CW'(RX_DEPTH))
    `ULBF_ASSERT(a_tx_count_bound, i_clk, i_rst_n, r_tx_count <= TX_CW'(TX_DEPTH))
    `ULBF_ASSERT(a_pop_gives_beat, i_clk, i_rst_n,
                 (r_state == ulbf_pkg::S_RXRD || r_state == ulbf_pkg::S_TXRD) |=> m_axis_tvalid)
    `ULBF_ASSERT(a_ovf_on_wire, i_clk, i_rst_n,
                 (m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tuser[0] && !m_axis_tuser[1]))
    `ULBF_ASSERT_ALWAYS(a_busy_no_ready, i_clk,
                        (r_state != ulbf_pkg::S_IDLE) |-> !s_axis_tready)

endmodule

// ===== src/ulbf_ram.sv =====
module ulbf_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int RXD = ulbf_pkg::RX_DEPTH_DEF;
    localparam int TXD = ulbf_pkg::TX_DEPTH_DEF;
    localparam logic [ulbf_pkg::ADDR_W-1:0] ADDR_EOL =
        ulbf_pkg::ADDR_W'(ulbf_pkg::REG_EOL * 4);

    typedef enum int {
        MIX_BALANCED,
        MIX_RX_HEAVY,
        MIX_TX_HEAVY
    } t_mix;

    typedef struct {
        ulbf_pkg::t_cmd    cmd;
        logic [7:0]        data;
        bit                typed;
        ulbf_pkg::t_result res;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ulbf_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_axis_tready;
    logic [7:0]                  s_tdata;
    logic [1:0]                  s_tuser;
    logic                        m_axis_tvalid;
    logic                        m_tready;
    logic [15:0]                 m_axis_tdata;
    logic [4:0]                  m_axis_tuser;
    logic                        m_axis_tlast;

    uart_line_buffered_fifos_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // line discipline state, mirrored
    logic [7:0] eol_q = ulbf_pkg::EOL_RESET;
    logic [7:0] rx_mem [RXD];
    logic [7:0] tx_mem [TXD];
    int         rx_wp = 0, rx_rp = 0, rx_cnt = 0;
    logic [7:0] rx_lines = 8'd0;
    int         tx_wp = 0, tx_rp = 0, tx_cnt = 0;

    ulbf_pkg::t_result exp_beats [$];
    t_stim_row         dir_tab [$];

    int n_fail = 0;
    int n_items = 0;
    int n_cfg = 0;
    int n_ovf = 0;
    int n_rej = 0;
    int n_rd_data = 0;
    int n_rd_empty = 0;
    int n_line = 0;

    bit send_gaps_on = 1'b1;
    bit recv_stalls_on = 1'b1;
    bit long_hold_req = 1'b0;

    function automatic ulbf_pkg::t_result res_fields(input logic lv, input logic [7:0] lb,
                                                     input logic rv, input logic [7:0] rb,
                                                     input logic re, input logic wr,
                                                     input logic ov, input logic lst);
        ulbf_pkg::t_result r;
        r.line_valid     = lv;
        r.line_byte      = lb;
        r.read_valid     = rv;
        r.read_byte      = rb;
        r.read_empty     = re;
        r.write_rejected = wr;
        r.overflow       = ov;
        r.last           = lst;
        return r;
    endfunction

    function automatic void predict_beats(input ulbf_pkg::t_cmd cmd, input logic [7:0] b);
        logic [7:0] c;
        case (cmd)
            ulbf_pkg::CMD_RX_BYTE: begin
                if (rx_cnt < RXD) begin
                    if (b == eol_q && rx_lines != ulbf_pkg::LINES_MAX)
                        rx_lines = rx_lines + 8'd1;
                    rx_mem[rx_wp] = b;
                    rx_wp = (rx_wp == RXD - 1) ? 0 : rx_wp + 1;
                    rx_cnt++;
                    exp_beats.push_back(res_fields(0, 0, 0, 0, 0, 0, 0, 1));
                end else begin
                    rx_wp = 0;
                    rx_rp = 0;
                    rx_cnt = 0;
                    rx_lines = 8'd0;
                    exp_beats.push_back(res_fields(1, ulbf_pkg::CH_B, 0, 0, 0, 0, 1, 0));
                    exp_beats.push_back(res_fields(1, ulbf_pkg::CH_O, 0, 0, 0, 0, 1, 0));
                    exp_beats.push_back(res_fields(1, ulbf_pkg::CH_F, 0, 0, 0, 0, 1, 0));
                    exp_beats.push_back(res_fields(1, eol_q, 0, 0, 0, 0, 1, 1));
                end
            end
            ulbf_pkg::CMD_HOST_RD: begin
                if (rx_cnt == 0 || rx_lines == 8'd0) begin
                    exp_beats.push_back(res_fields(0, 0, 0, 0, 1, 0, 0, 1));
                end else begin
                    c = rx_mem[rx_rp];
                    rx_rp = (rx_rp == RXD - 1) ? 0 : rx_rp + 1;
                    rx_cnt--;
                    if (c == eol_q) begin
                        c = ulbf_pkg::NL_BYTE;
                        rx_lines = rx_lines - 8'd1;
                    end
                    exp_beats.push_back(res_fields(0, 0, 1, c, 0, 0, 0, 1));
                end
            end
            ulbf_pkg::CMD_HOST_WR: begin
                c = (b == ulbf_pkg::NL_BYTE) ? eol_q : b;
                if (tx_cnt >= TXD) begin
                    exp_beats.push_back(res_fields(0, 0, 0, 0, 0, 1, 0, 1));
                end else begin
                    tx_mem[tx_wp] = c;
                    tx_wp = (tx_wp == TXD - 1) ? 0 : tx_wp + 1;
                    tx_cnt++;
                    exp_beats.push_back(res_fields(0, 0, 0, 0, 0, 0, 0, 1));
                end
            end
            default: begin
                if (tx_cnt > 0) begin
                    c = tx_mem[tx_rp];
                    tx_rp = (tx_rp == TXD - 1) ? 0 : tx_rp + 1;
                    tx_cnt--;
                    exp_beats.push_back(res_fields(1, c, 0, 0, 0, 0, 0, 1));
                end else begin
                    exp_beats.push_back(res_fields(0, 0, 0, 0, 0, 0, 0, 1));
                end
            end
        endcase
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        ulbf_pkg::t_result act, e;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_tready === 1'b1) begin
            act = res_fields(m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tuser[1],
                             m_axis_tdata[15:8], m_axis_tuser[2], m_axis_tuser[3],
                             m_axis_tuser[4], m_axis_tlast);
            if (exp_beats.size() == 0) begin
                $error("unexpected result beat %h", act);
                n_fail++;
            end else begin
                e = exp_beats.pop_front();
                cmp_field("line_valid", e.line_valid, act.line_valid);
                cmp_field("line_byte", e.line_byte, act.line_byte);
                cmp_field("read_valid", e.read_valid, act.read_valid);
                cmp_field("read_byte", e.read_byte, act.read_byte);
                cmp_field("read_empty", e.read_empty, act.read_empty);
                cmp_field("write_rejected", e.write_rejected, act.write_rejected);
                cmp_field("overflow", e.overflow, act.overflow);
                cmp_field("last", e.last, act.last);
                if (e.overflow && e.last) n_ovf++;
                if (e.write_rejected) n_rej++;
                if (e.read_valid) n_rd_data++;
                if (e.read_empty) n_rd_empty++;
                if (e.line_valid && !e.overflow) n_line++;
            end
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        m_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin : recv_loop
            int w;
            w = recv_stalls_on ? $urandom_range(0, 8) : 0;
            if (long_hold_req) begin
                w = 80;
                long_hold_req = 1'b0;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk); while (exp_beats.size() != 0);
    endtask

    task automatic send_beat(input ulbf_pkg::t_cmd cmd, input logic [7:0] b,
                             input bit typed, input ulbf_pkg::t_result res);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_beats(cmd, b);
        if (typed) begin
            void'(exp_beats.pop_back());
            exp_beats.push_back(res);
        end
        n_items++;
    endtask

    task automatic set_eol(input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_EOL;
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        eol_q = val;
        n_cfg++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        cmp_field("eol_char readback", val, prdata[7:0]);
        cmp_field("pready", 8'd1, {7'd0, pready});
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input t_mix mix, input int n, input bit gaps,
                             input bit stalls, input bit pause_mid);
        int             i, r;
        ulbf_pkg::t_cmd cmd;
        logic [7:0]     b;
        send_gaps_on = gaps;
        recv_stalls_on = stalls;
        for (i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            case (mix)
                MIX_RX_HEAVY:
                    cmd = (r < 85) ? ulbf_pkg::CMD_RX_BYTE :
                          (r < 95) ? ulbf_pkg::CMD_HOST_RD :
                          (r < 98) ? ulbf_pkg::CMD_HOST_WR : ulbf_pkg::CMD_TX_RDY;
                MIX_TX_HEAVY:
                    cmd = (r < 80) ? ulbf_pkg::CMD_HOST_WR :
                          (r < 90) ? ulbf_pkg::CMD_TX_RDY :
                          (r < 95) ? ulbf_pkg::CMD_RX_BYTE : ulbf_pkg::CMD_HOST_RD;
                default:
                    cmd = (r < 35) ? ulbf_pkg::CMD_RX_BYTE :
                          (r < 60) ? ulbf_pkg::CMD_HOST_RD :
                          (r < 85) ? ulbf_pkg::CMD_HOST_WR : ulbf_pkg::CMD_TX_RDY;
            endcase
            b = 8'($urandom_range(0, 255));
            if (cmd == ulbf_pkg::CMD_RX_BYTE && $urandom_range(0, 3) == 0)
                b = eol_q;
            if (cmd == ulbf_pkg::CMD_HOST_WR && $urandom_range(0, 4) == 0)
                b = ulbf_pkg::NL_BYTE;
            send_beat(cmd, b, 1'b0, res_fields(0, 0, 0, 0, 0, 0, 0, 0));
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int k;
        t_stim_row row;
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;

        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'hFF, 1,
                            res_fields(0, 0, 0, 0, 1, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'hFF, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_RX_BYTE, 8'h00, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_RX_BYTE, 8'hFF, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'h00, 1,
                            res_fields(0, 0, 0, 0, 1, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_RX_BYTE, 8'h0D, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'h00, 1,
                            res_fields(0, 0, 1, 8'h00, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'hFF, 1,
                            res_fields(0, 0, 1, 8'hFF, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'h00, 1,
                            res_fields(0, 0, 1, 8'h0A, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'h00, 1,
                            res_fields(0, 0, 0, 0, 1, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_WR, 8'h0A, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_WR, 8'hFF, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_WR, 8'h00, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'h00, 1,
                            res_fields(1, 8'h0D, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'hFF, 1,
                            res_fields(1, 8'hFF, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'h00, 1,
                            res_fields(1, 8'h00, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'h00, 1,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ulbf_pkg::CMD_RX_BYTE, 8'h0A, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{ulbf_pkg::CMD_RX_BYTE, 8'h0D, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'h55, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_RD, 8'hAA, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{ulbf_pkg::CMD_HOST_WR, 8'h0D, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{ulbf_pkg::CMD_TX_RDY,  8'h00, 0,
                            res_fields(0, 0, 0, 0, 0, 0, 0, 0)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_tab.size(); k++) begin
            row = dir_tab[k];
            send_beat(row.cmd, row.data, row.typed, row.res);
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        run_phase(MIX_BALANCED, 35, 1, 1, 0);
        set_eol(8'h00);
        run_phase(MIX_RX_HEAVY, 45, 0, 1, 0);
        set_eol(8'hFF);
        long_hold_req = 1'b1;
        run_phase(MIX_TX_HEAVY, 40, 0, 1, 0);
        set_eol(ulbf_pkg::NL_BYTE);
        run_phase(MIX_BALANCED, 35, 0, 0, 0);
        set_eol(8'($urandom_range(0, 255)));
        run_phase(MIX_RX_HEAVY, 45, 1, 0, 0);
        set_eol(8'($urandom_range(0, 255)));
        run_phase(MIX_TX_HEAVY, 40, 1, 1, 0);
        set_eol(ulbf_pkg::EOL_RESET);
        run_phase(MIX_BALANCED, 25, 1, 1, 1);
        set_eol(8'($urandom_range(0, 255)));
        run_phase(MIX_BALANCED, 22, 1, 1, 0);

        repeat (20) @(posedge i_clk);
        if (exp_beats.size() != 0) begin
            $error("%0d result beats never arrived", exp_beats.size());
            n_fail++;
        end
        $display("covered %0d input beats over %0d end-of-line settings, with gaps and stalls",
                 n_items, n_cfg + 1);
        $display("%0d overflow bursts, %0d rejected writes, %0d reads with data,",
                 n_ovf, n_rej, n_rd_data);
        $display("%0d empty reads, %0d bytes sent on the wire", n_rd_empty, n_line);
        if (n_fail == 0) begin
            $display("[uart_line_buffered_fifos_core] OK");
        end else begin
            $display("[uart_line_buffered_fifos_core] ERROR");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("[uart_line_buffered_fifos_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ulbf_pkg.sv
src/ulbf_ram.sv
src/uart_line_buffered_fifos_core.sv
tb/tb.sv
